FILE: rtl/bcf_pkg.sv
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types, widths and weight function for the Bezier curve flattener.
// ----------------------------------------------------------------------------
package bcf_pkg;

	localparam int SEGMENTS_DEF    = 10;
	localparam int SEG_MAX         = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int COORD_W = 16;
	localparam int STEP_W  = 5;
	localparam int TAB_N   = SEG_MAX + 1;
	localparam int W_W     = 13;
	localparam int PROD_W  = COORD_W + W_W + 1;
	localparam int SUM_W   = PROD_W + 2;
	localparam int M_W     = 28;
	localparam int RCP_SH  = 28;
	localparam int RCP_W   = 27;
	localparam int Q_W     = 17;
	localparam int DEN_W   = 13;
	localparam int QD_W    = Q_W + DEN_W;

	localparam int NUM_AXES = 2;
	localparam int NUM_PTS  = 4;

	typedef logic signed [COORD_W-1:0] bcf_coord_t;

	typedef struct packed {
		logic       cubic;
		bcf_coord_t x0;
		bcf_coord_t y0;
		bcf_coord_t x1;
		bcf_coord_t y1;
		bcf_coord_t x2;
		bcf_coord_t y2;
		bcf_coord_t x3;
		bcf_coord_t y3;
	} bcf_req_t;

	// Bernstein weight k of step i for s segments, scaled by s^2 or s^3
	function automatic int bcf_weight(int s, int i, int k, logic cubic);
		int r;
		int w;
		r = s - i;
		w = 0;
		if (i >= 1 && i <= s) begin
			if (cubic) begin
				unique case (k)
					0:       w = r * r * r;
					1:       w = 3 * r * r * i;
					2:       w = 3 * r * i * i;
					3:       w = i * i * i;
					default: w = 0;
				endcase
			end else begin
				unique case (k)
					0:       w = r * r;
					1:       w = 2 * r * i;
					2:       w = i * i;
					default: w = 0;
				endcase
			end
		end
		return w;
	endfunction

endpackage

FILE: rtl/bcf_front.sv
// ----------------------------------------------------------------------------
// bcf_front
// Accepts curve requests, classifies the order and registers one request
// for the queue.
// ----------------------------------------------------------------------------
module bcf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  bcf_pkg::bcf_coord_t start_x,
	input  bcf_pkg::bcf_coord_t start_y,
	input  bcf_pkg::bcf_coord_t ctrl1_x,
	input  bcf_pkg::bcf_coord_t ctrl1_y,
	input  bcf_pkg::bcf_coord_t ctrl2_x,
	input  bcf_pkg::bcf_coord_t ctrl2_y,
	input  bcf_pkg::bcf_coord_t ctrl3_x,
	input  bcf_pkg::bcf_coord_t ctrl3_y,
	output logic                push_valid,
	input  logic                push_ready,
	output bcf_pkg::bcf_req_t   push_data
);

	logic              req_vld_q;
	bcf_pkg::bcf_req_t req_q;
	bcf_pkg::bcf_req_t req_c;

	// quadratic requests carry no fourth point
	always_comb begin
		req_c.cubic = op;
		req_c.x0    = start_x;
		req_c.y0    = start_y;
		req_c.x1    = ctrl1_x;
		req_c.y1    = ctrl1_y;
		req_c.x2    = ctrl2_x;
		req_c.y2    = ctrl2_y;
		req_c.x3    = op ? ctrl3_x : '0;
		req_c.y3    = op ? ctrl3_y : '0;
	end

	assign in_ready   = !req_vld_q || push_ready;
	assign push_valid = req_vld_q;
	assign push_data  = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_q <= 1'b0;
		end else if (in_ready) begin
			req_vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= req_c;
		end
	end

endmodule

FILE: rtl/bcf_queue.sv
// ----------------------------------------------------------------------------
// bcf_queue
// Short request queue between the front and the point generator.
// ----------------------------------------------------------------------------
module bcf_queue #(
	parameter int DEPTH = bcf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  bcf_pkg::bcf_req_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output bcf_pkg::bcf_req_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bcf_pkg::bcf_req_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/bcf_back.sv
// ----------------------------------------------------------------------------
// bcf_back
// Steps through the SEGMENTS steps of each request and evaluates the curve
// points in a pipeline: weights, products, sum, rounding, reciprocal divide.
// ----------------------------------------------------------------------------
module bcf_back #(
	parameter int SEGMENTS = bcf_pkg::SEGMENTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pop_valid,
	output logic                      pop_ready,
	input  bcf_pkg::bcf_req_t         pop_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bcf_pkg::bcf_coord_t       point_x,
	output bcf_pkg::bcf_coord_t       point_y,
	output logic [bcf_pkg::STEP_W-1:0] step_index,
	output logic                      last_point
);

	localparam int COORD_W = bcf_pkg::COORD_W;
	localparam int STEP_W  = bcf_pkg::STEP_W;
	localparam int W_W     = bcf_pkg::W_W;
	localparam int PROD_W  = bcf_pkg::PROD_W;
	localparam int SUM_W   = bcf_pkg::SUM_W;
	localparam int M_W     = bcf_pkg::M_W;
	localparam int RCP_SH  = bcf_pkg::RCP_SH;
	localparam int RCP_W   = bcf_pkg::RCP_W;
	localparam int Q_W     = bcf_pkg::Q_W;
	localparam int DEN_W   = bcf_pkg::DEN_W;
	localparam int QD_W    = bcf_pkg::QD_W;
	localparam int NA      = bcf_pkg::NUM_AXES;
	localparam int NP      = bcf_pkg::NUM_PTS;

	localparam int DEN_Q  = SEGMENTS * SEGMENTS;
	localparam int DEN_C  = DEN_Q * SEGMENTS;
	localparam int HALF_Q = DEN_Q / 2;
	localparam int HALF_C = DEN_C / 2;
	localparam int RCP_Q  = (1 << RCP_SH) / DEN_Q;
	localparam int RCP_C  = (1 << RCP_SH) / DEN_C;

	// weight tables, constant per SEGMENTS
	logic [W_W-1:0] wq_tab [bcf_pkg::TAB_N][NP];
	logic [W_W-1:0] wc_tab [bcf_pkg::TAB_N][NP];

	for (genvar g = 0; g < bcf_pkg::TAB_N; g++) begin : g_tab
		for (genvar k = 0; k < NP; k++) begin : g_w
			assign wq_tab[g][k] = W_W'(bcf_pkg::bcf_weight(SEGMENTS, g, k, 1'b0));
			assign wc_tab[g][k] = W_W'(bcf_pkg::bcf_weight(SEGMENTS, g, k, 1'b1));
		end
	end

	logic en;

	// step sequencer
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	bcf_pkg::bcf_req_t req_q;
	logic              issue_last;
	logic              load;

	assign en         = !out_valid || out_ready;
	assign issue_last = busy_q && (step_q == STEP_W'(SEGMENTS));
	assign pop_ready  = en && (!busy_q || issue_last);
	assign load       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (en) begin
			if (load) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(1);
			end else if (issue_last) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_q <= pop_data;
		end
	end

	bcf_pkg::bcf_coord_t req_crd [NA][NP];

	always_comb begin
		req_crd[0][0] = req_q.x0;
		req_crd[0][1] = req_q.x1;
		req_crd[0][2] = req_q.x2;
		req_crd[0][3] = req_q.x3;
		req_crd[1][0] = req_q.y0;
		req_crd[1][1] = req_q.y1;
		req_crd[1][2] = req_q.y2;
		req_crd[1][3] = req_q.y3;
	end

	// pipeline valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= busy_q;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			out_valid <= v_s6;
		end
	end

	// side-band carried along the pipe
	logic              cub_s1, cub_s2, cub_s3, cub_s4, cub_s5, cub_s6;
	logic [STEP_W-1:0] stp_s1, stp_s2, stp_s3, stp_s4, stp_s5, stp_s6;
	logic              lst_s1, lst_s2, lst_s3, lst_s4, lst_s5, lst_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			cub_s1 <= req_q.cubic;
			stp_s1 <= step_q;
			lst_s1 <= issue_last;
			cub_s2 <= cub_s1;
			stp_s2 <= stp_s1;
			lst_s2 <= lst_s1;
			cub_s3 <= cub_s2;
			stp_s3 <= stp_s2;
			lst_s3 <= lst_s2;
			cub_s4 <= cub_s3;
			stp_s4 <= stp_s3;
			lst_s4 <= lst_s3;
			cub_s5 <= cub_s4;
			stp_s5 <= stp_s4;
			lst_s5 <= lst_s4;
			cub_s6 <= cub_s5;
			stp_s6 <= stp_s5;
			lst_s6 <= lst_s5;
		end
	end

	// s1: weight lookup
	bcf_pkg::bcf_coord_t crd_s1 [NA][NP];
	logic [W_W-1:0]      w_s1   [NP];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NP; k++) begin
				w_s1[k] <= req_q.cubic ? wc_tab[step_q][k] : wq_tab[step_q][k];
				for (int a = 0; a < NA; a++) begin
					crd_s1[a][k] <= req_crd[a][k];
				end
			end
		end
	end

	// s2: products
	logic signed [PROD_W-1:0] prod_c  [NA][NP];
	logic signed [PROD_W-1:0] prod_s2 [NA][NP];

	always_comb begin
		for (int a = 0; a < NA; a++) begin
			for (int k = 0; k < NP; k++) begin
				prod_c[a][k] = $signed({1'b0, w_s1[k]}) * crd_s1[a][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod_c;
		end
	end

	// s3: weighted sum
	logic signed [SUM_W-1:0] sum_s3 [NA];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NA; a++) begin
				sum_s3[a] <= SUM_W'(prod_s2[a][0]) + SUM_W'(prod_s2[a][1])
					+ SUM_W'(prod_s2[a][2]) + SUM_W'(prod_s2[a][3]);
			end
		end
	end

	// s4: magnitude plus half divisor
	logic [SUM_W-1:0] mag_c [NA];
	logic [M_W-1:0]   half_c;
	logic [M_W-1:0]   m_s4  [NA];
	logic             neg_s4 [NA];

	assign half_c = cub_s3 ? M_W'(HALF_C) : M_W'(HALF_Q);

	always_comb begin
		for (int a = 0; a < NA; a++) begin
			mag_c[a] = sum_s3[a][SUM_W-1] ? SUM_W'(-sum_s3[a]) : SUM_W'(sum_s3[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NA; a++) begin
				neg_s4[a] <= sum_s3[a][SUM_W-1];
				m_s4[a]   <= mag_c[a][M_W-1:0] + half_c;
			end
		end
	end

	// s5: quotient estimate through reciprocal, low by at most one
	logic [RCP_W-1:0]     rcp_c;
	logic [M_W+RCP_W-1:0] mr_c  [NA];
	logic [Q_W-1:0]       q0_s5 [NA];
	logic [M_W-1:0]       m_s5  [NA];
	logic                 neg_s5 [NA];

	assign rcp_c = cub_s4 ? RCP_W'(RCP_C) : RCP_W'(RCP_Q);

	always_comb begin
		for (int a = 0; a < NA; a++) begin
			mr_c[a] = (M_W + RCP_W)'(m_s4[a]) * (M_W + RCP_W)'(rcp_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NA; a++) begin
				q0_s5[a]  <= mr_c[a][RCP_SH+Q_W-1:RCP_SH];
				m_s5[a]   <= m_s4[a];
				neg_s5[a] <= neg_s4[a];
			end
		end
	end

	// s6: back-multiply for the remainder
	logic [DEN_W-1:0] den_s5;
	logic [QD_W-1:0]  qd_s6 [NA];
	logic [Q_W-1:0]   q0_s6 [NA];
	logic [M_W-1:0]   m_s6  [NA];
	logic             neg_s6 [NA];

	assign den_s5 = cub_s5 ? DEN_W'(DEN_C) : DEN_W'(DEN_Q);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NA; a++) begin
				qd_s6[a]  <= QD_W'(q0_s5[a]) * QD_W'(den_s5);
				q0_s6[a]  <= q0_s5[a];
				m_s6[a]   <= m_s5[a];
				neg_s6[a] <= neg_s5[a];
			end
		end
	end

	// output: correct estimate, restore sign
	logic [DEN_W-1:0] den_s6;
	logic [QD_W-1:0]  rem_c [NA];
	logic [Q_W-1:0]   q_c   [NA];
	logic [Q_W-1:0]   pt_c  [NA];

	assign den_s6 = cub_s6 ? DEN_W'(DEN_C) : DEN_W'(DEN_Q);

	always_comb begin
		for (int a = 0; a < NA; a++) begin
			rem_c[a] = QD_W'(m_s6[a]) - qd_s6[a];
			q_c[a]   = (rem_c[a] >= QD_W'(den_s6)) ? q0_s6[a] + 1'b1 : q0_s6[a];
			pt_c[a]  = neg_s6[a] ? Q_W'(-q_c[a]) : q_c[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s6) begin
			point_x    <= pt_c[0][COORD_W-1:0];
			point_y    <= pt_c[1][COORD_W-1:0];
			step_index <= stp_s6;
			last_point <= lst_s6;
		end
	end

endmodule

FILE: rtl/bezier_curve_flattener.sv
// ----------------------------------------------------------------------------
// bezier_curve_flattener
// Uniform-step flattening of quadratic and cubic Bezier curves.
// ----------------------------------------------------------------------------
// One input word is a curve: op selects quadratic (0) or cubic (1), followed
// by the start point and up to three control points in signed Q12.4. Each
// accepted word yields SEGMENTS output words, the points at t = i/SEGMENTS
// for i = 1..SEGMENTS, rounded half away from zero; last_point marks i =
// SEGMENTS. Both channels are valid/ready.
// The front registers and classifies the request and writes it into a
// QUEUE_DEPTH entry queue. The point generator reads one request and issues
// one step per cycle, while the output is not stalled, into a seven stage
// arithmetic pipe ending in the output register, so a curve occupies the
// generator for its SEGMENTS steps and a new curve is taken while the last
// step of the current curve issues.
// While an output word waits with out_ready low the whole pipe holds; the
// front and queue keep accepting words until the queue fills. Reset clears
// the queue, the step sequencer and all valid flags; no word is in flight
// after reset.
// ----------------------------------------------------------------------------
module bezier_curve_flattener #(
	parameter int SEGMENTS    = bcf_pkg::SEGMENTS_DEF,
	parameter int QUEUE_DEPTH = bcf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  bcf_pkg::bcf_coord_t        start_x,
	input  bcf_pkg::bcf_coord_t        start_y,
	input  bcf_pkg::bcf_coord_t        ctrl1_x,
	input  bcf_pkg::bcf_coord_t        ctrl1_y,
	input  bcf_pkg::bcf_coord_t        ctrl2_x,
	input  bcf_pkg::bcf_coord_t        ctrl2_y,
	input  bcf_pkg::bcf_coord_t        ctrl3_x,
	input  bcf_pkg::bcf_coord_t        ctrl3_y,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bcf_pkg::bcf_coord_t        point_x,
	output bcf_pkg::bcf_coord_t        point_y,
	output logic [bcf_pkg::STEP_W-1:0] step_index,
	output logic                       last_point
);

	logic              push_valid;
	logic              push_ready;
	bcf_pkg::bcf_req_t push_data;
	logic              pop_valid;
	logic              pop_ready;
	bcf_pkg::bcf_req_t pop_data;

	bcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.start_x    (start_x),
		.start_y    (start_y),
		.ctrl1_x    (ctrl1_x),
		.ctrl1_y    (ctrl1_y),
		.ctrl2_x    (ctrl2_x),
		.ctrl2_y    (ctrl2_y),
		.ctrl3_x    (ctrl3_x),
		.ctrl3_y    (ctrl3_y),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bcf_back #(
		.SEGMENTS (SEGMENTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.step_index (step_index),
		.last_point (last_point)
	);

endmodule

FILE: rtl/bcf_checker.sv
// ----------------------------------------------------------------------------
// bcf_checker
// Port-level checks for the Bezier curve flattener, bound to the top level.
// ----------------------------------------------------------------------------
module bcf_checker #(
	parameter int SEGMENTS = bcf_pkg::SEGMENTS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input bcf_pkg::bcf_coord_t        point_x,
	input bcf_pkg::bcf_coord_t        point_y,
	input logic [bcf_pkg::STEP_W-1:0] step_index,
	input logic                       last_point
);

	localparam int STEP_W = bcf_pkg::STEP_W;

	logic [STEP_W-1:0] exp_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_step_q <= STEP_W'(1);
		end else if (out_valid && out_ready) begin
			exp_step_q <= last_point ? STEP_W'(1) : exp_step_q + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(point_x) && $stable(point_y)
			&& $stable(step_index) && $stable(last_point))
		else $error("output word changed while stalled");

	a_step_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> step_index == exp_step_q)
		else $error("step index out of sequence");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_point == (step_index == STEP_W'(SEGMENTS)))
		else $error("last point flag does not match final step");

endmodule

bind bezier_curve_flattener bcf_checker #(
	.SEGMENTS (SEGMENTS)
) u_bcf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.point_x    (point_x),
	.point_y    (point_y),
	.step_index (step_index),
	.last_point (last_point)
);
